>>> hdl/ipv4_lpm_pkg.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_pkg
// Shared widths, codes, types and the prefix mask function for the
// IPv4 longest-prefix-match table.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4_lpm_pkg;

  // field widths
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int NUM_W       = 7;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = ADDR_W + LEN_W;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // longest legal prefix
  localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

  // item kinds on the input tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result codes on the output tuser
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MATCH    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd3;

  // result of one entry compare
  typedef struct packed {
    logic             hit;   // entry matches and beats the current best
    logic [LEN_W-1:0] len;   // length of the entry compared
  } cmp_result_t;

  // mask of the top len bits; len is at most 32
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return ~(ones >> len);
  endfunction

endpackage

`default_nettype wire

>>> hdl/ipv4_lpm_ram.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_lpm_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/ipv4_lpm_cmp.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_cmp
// Shared compare unit: masks the lookup address to a stored prefix length
// and tests it against the stored prefix and the current best length.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_lpm_cmp (
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0] addr,
  input  wire logic [ipv4_lpm_pkg::ADDR_W-1:0] entry_bits,
  input  wire logic [ipv4_lpm_pkg::LEN_W-1:0]  entry_len,
  input  wire logic [ipv4_lpm_pkg::LEN_W-1:0]  best_len,
  output      ipv4_lpm_pkg::cmp_result_t       result
);

  logic prefix_eq;

  // masked compare; zero-length entries never beat best (best >= 0)
  assign prefix_eq   = (addr & ipv4_lpm_pkg::len_mask(entry_len)) == entry_bits;
  assign result.hit  = prefix_eq && (entry_len > best_len);
  assign result.len  = entry_len;

endmodule

`default_nettype wire

>>> hdl/ipv4_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match
// IPv4 route table with longest-prefix-match lookup.
// ----------------------------------------------------------------------------
// Insert items (tuser 0) store the top prefix_length bits of an address in
// the next free slot and return its 1-based slot number, or status "full".
// Lookup items (tuser 1) return the slot with the longest matching prefix,
// earliest slot on ties; zero-length prefixes never match. One item is
// worked at a time and s_tready is low meanwhile. An insert passes through
// the insert and result states on its way to the output register. A lookup
// has a single compare unit walk the stored entries one per cycle through
// the registered read port of the prefix RAM, then passes through the
// result state. The input opens again as the result is loaded into the
// output register. A finished result sits in the output register, so the
// next item is accepted while it waits to be taken. Stored entries have no
// reset; of the table, only the fill count is cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_longest_prefix_match #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input items
  input  wire logic                                  s_tvalid,
  output      logic                                  s_tready,
  input  wire logic [ipv4_lpm_pkg::IN_TDATA_W-1:0]   s_tdata,  // address[31:0], prefix_length[37:32]
  input  wire logic                                  s_tuser,  // op
  // result items
  output      logic                                  m_tvalid,
  input  wire logic                                  m_tready,
  output      logic [ipv4_lpm_pkg::OUT_TDATA_W-1:0]  m_tdata,  // entry_number[6:0], matched_length[12:7]
  output      logic [ipv4_lpm_pkg::STATUS_W-1:0]     m_tuser   // status
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_COUNT = CW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_INSERT = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state;

  // latched item
  logic [ipv4_lpm_pkg::ADDR_W-1:0] item_addr;
  logic [ipv4_lpm_pkg::LEN_W-1:0]  item_len;

  // table fill and scan
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   scan_idx;
  logic                            pend;
  logic [CW-1:0]                   pend_num;
  logic [ipv4_lpm_pkg::LEN_W-1:0]  best_len;
  logic [CW-1:0]                   best_num;

  // pending result
  logic [ipv4_lpm_pkg::STATUS_W-1:0] res_status;
  logic [ipv4_lpm_pkg::NUM_W-1:0]    res_num;
  logic [ipv4_lpm_pkg::LEN_W-1:0]    res_len;

  // output register
  logic [ipv4_lpm_pkg::NUM_W-1:0]    out_num;
  logic [ipv4_lpm_pkg::LEN_W-1:0]    out_len;
  logic [ipv4_lpm_pkg::STATUS_W-1:0] out_status;

  // RAM and compare unit
  logic                              ram_we;
  logic [ipv4_lpm_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [ipv4_lpm_pkg::ENTRY_W-1:0]  ram_rdata;
  ipv4_lpm_pkg::cmp_result_t         cmp;

  logic                              table_full;
  logic                              issue;
  logic                              out_free;
  logic [ipv4_lpm_pkg::LEN_W-1:0]    in_len;
  logic [31:0]                       best_num_wide;
  logic [31:0]                       ins_num_wide;

  assign s_tready   = (state == ST_IDLE);
  assign table_full = (count >= LAST_COUNT);
  assign issue      = (state == ST_SCAN) && (scan_idx < count);
  assign out_free   = !m_tvalid || m_tready;
  assign ram_we     = (state == ST_INSERT) && !table_full;
  assign ram_wdata  = {item_len, item_addr & ipv4_lpm_pkg::len_mask(item_len)};

  // saturate the incoming length to 32
  assign in_len = (s_tdata[37:32] > ipv4_lpm_pkg::MAX_LEN) ? ipv4_lpm_pkg::MAX_LEN
                                                            : s_tdata[37:32];

  // slot numbers folded to the 7-bit result field
  assign best_num_wide = 32'(best_num);
  assign ins_num_wide  = 32'(count) + 32'd1;

  ipv4_lpm_ram #(
    .WIDTH (ipv4_lpm_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (scan_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  ipv4_lpm_cmp u_cmp (
    .addr       (item_addr),
    .entry_bits (ram_rdata[ipv4_lpm_pkg::ADDR_W-1:0]),
    .entry_len  (ram_rdata[ipv4_lpm_pkg::ENTRY_W-1:ipv4_lpm_pkg::ADDR_W]),
    .best_len   (best_len),
    .result     (cmp)
  );

  // sequencer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pend  <= 1'b0;
            state <= (s_tuser == ipv4_lpm_pkg::OP_LOOKUP) ? ST_SCAN : ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (!table_full) begin
            count <= count + 1'b1;
          end
          state <= ST_RESULT;
        end
        ST_SCAN: begin
          pend <= issue;
          if (!issue && !pend) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item latch, scan datapath and pending result
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          item_addr <= s_tdata[31:0];
          item_len  <= in_len;
          scan_idx  <= '0;
          best_len  <= '0;
          best_num  <= '0;
        end
      end
      ST_INSERT: begin
        if (table_full) begin
          res_status <= ipv4_lpm_pkg::STATUS_FULL;
          res_num    <= '0;
        end else begin
          res_status <= ipv4_lpm_pkg::STATUS_INSERTED;
          res_num    <= ins_num_wide[ipv4_lpm_pkg::NUM_W-1:0];
        end
        res_len <= '0;
      end
      ST_SCAN: begin
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
          pend_num <= scan_idx + 1'b1;
        end
        if (pend && cmp.hit) begin
          best_len <= cmp.len;
          best_num <= pend_num;
        end
        if (!issue && !pend) begin
          res_status <= (best_len != '0) ? ipv4_lpm_pkg::STATUS_MATCH
                                         : ipv4_lpm_pkg::STATUS_NO_MATCH;
          res_num    <= best_num_wide[ipv4_lpm_pkg::NUM_W-1:0];
          res_len    <= best_len;
        end
      end
      ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      out_status <= res_status;
      out_num    <= res_num;
      out_len    <= res_len;
    end
  end

  assign m_tdata = {3'b000, out_len, out_num};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

>>> hdl/ipv4_lpm_checker.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_checker
// Port-level checks for the IPv4 longest-prefix-match table, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_lpm_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 s_tvalid,
  input wire logic                                 s_tready,
  input wire logic                                 m_tvalid,
  input wire logic                                 m_tready,
  input wire logic [ipv4_lpm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic [ipv4_lpm_pkg::STATUS_W-1:0]    m_tuser
);

  // no result straight out of reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one item at a time: input closes after an accept
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after accepting an item");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // insert, full and miss results carry no matched length; full and miss no slot
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ipv4_lpm_pkg::STATUS_INSERTED ||
                  m_tuser == ipv4_lpm_pkg::STATUS_FULL ||
                  m_tuser == ipv4_lpm_pkg::STATUS_NO_MATCH))
    |-> (m_tdata[12:7] == '0) &&
        (m_tuser == ipv4_lpm_pkg::STATUS_INSERTED || m_tdata[6:0] == '0))
    else $error("non-match result carries match fields");

  // a match has a nonzero length of at most 32
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ipv4_lpm_pkg::STATUS_MATCH)
    |-> (m_tdata[12:7] != '0) && (m_tdata[12:7] <= ipv4_lpm_pkg::MAX_LEN))
    else $error("match result with bad length");

endmodule

bind ipv4_longest_prefix_match ipv4_lpm_checker u_checker (.*);

`default_nettype wire
